// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, c)
`define ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/mphf_pkg.sv =====
// ----------------------------------------------------------------------------
// mphf package
// shared types and constants of the minimal perfect hash lookup core
// ----------------------------------------------------------------------------
package mphf_pkg;
    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_WR_DISP = 2'd1;
    localparam logic [1:0] OP_WR_FP = 2'd2;
    localparam logic [1:0] OP_WR_VAL = 2'd3;

    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT = 3'd1;
    localparam logic [2:0] ST_FP_MISMATCH = 3'd2;
    localparam logic [2:0] ST_VALUE_RANGE = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;
    localparam logic [2:0] ST_INDEX_RANGE = 3'd5;

    localparam logic [1:0] CFG_BUCKETS = 2'd0;
    localparam logic [1:0] CFG_ENTRIES = 2'd1;
    localparam logic [1:0] CFG_UNIQUE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [13:0] table_index;
        logic [15:0] table_data;
        logic [3:0]  stroke_count;
        logic [31:0] stroke_0;
        logic [31:0] stroke_1;
        logic [31:0] stroke_2;
        logic [31:0] stroke_3;
        logic [31:0] stroke_4;
        logic [31:0] stroke_5;
        logic [31:0] stroke_6;
        logic [31:0] stroke_7;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value_id;
        logic [13:0] slot;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_MOD, S_RD_DISP, S_RD_SLOT, S_CHECK, S_DONE
    } t_state;
endpackage

// ===== design/mphf_fnv.sv =====
// ----------------------------------------------------------------------------
// mphf fnv unit
// one fnv-1a byte step per cycle while i_step is high, on a 32-bit accumulator
// ----------------------------------------------------------------------------
module mphf_fnv (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_init,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_hash
);
    import mphf_pkg::*;
    logic [31:0] r_hash;
    logic [31:0] n_hash;

    always_comb begin
        n_hash = r_hash;
        if (i_load) begin
            n_hash = i_init;
        end else if (i_step) begin
            n_hash = (r_hash ^ {24'd0, i_byte}) * FNV_PRIME;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_hash = r_hash;
endmodule

// ===== design/mphf_mod.sv =====
// ----------------------------------------------------------------------------
// mphf modulo unit
// restoring remainder of a 32-bit value, one bit per cycle
// ----------------------------------------------------------------------------
module mphf_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [16:0] o_rem
);
    import mphf_pkg::*;
    logic [31:0] r_num;
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    logic [17:0] w_sub;

    assign w_sh = {r_rem, r_num[31]};
    assign w_sub = w_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd32;
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_sub[17] ? w_sh[16:0] : w_sub[16:0];
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_rem = r_rem;
endmodule

// ===== design/mphf_dictionary_lookup_core.sv =====
// ----------------------------------------------------------------------------
// mphf dictionary lookup core
// hash-and-displace minimal perfect hash lookup with table load port
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low. A table write
// or a bad stroke count goes straight to the final state, and its result
// strobes in the cycle after. A lookup runs one shared fnv byte unit over
// three passes: seed 0, plain, and seed d+1. Each seeded pass hashes 4 seed
// bytes and then 4n stroke bytes, where n is stroke_count. The plain pass
// hashes the 4n stroke bytes only. A bit-serial remainder unit runs twice,
// for the bucket and for the slot. The displacement read, slot read, check
// and final state follow, and the result strobes in the cycle after. o_rsp
// carries the result with o_done, which is high for one cycle, and holds it
// until the next transaction; the receiver cannot stall, so the core never
// waits on it. The tables come up undefined and need no clear pass.
module mphf_dictionary_lookup_core #(
    parameter int MAX_STROKES = 8,
    parameter int NUM_BUCKETS = 4096,
    parameter int NUM_SLOTS = 16384,
    parameter int DISP_WIDTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mphf_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_done,
    output mphf_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import mphf_pkg::*;
    `include "assert_macros.svh"

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int SW = $clog2(NUM_SLOTS);

    // tables
    logic [DISP_WIDTH-1:0]  disp_mem [NUM_BUCKETS];
    logic [7:0]             fp_mem [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0] val_mem [NUM_SLOTS];
    logic [DISP_WIDTH-1:0]  r_disp_q;
    logic [7:0]             r_fp_q;
    logic [VALUE_WIDTH-1:0] r_val_q;

    // config registers
    logic [12:0] r_nb;
    logic [14:0] r_ne;
    logic [16:0] r_nu;

    t_state r_state, n_state;
    t_req   r_req;
    logic [1:0]  r_pass, n_pass;      // 0 seed0, 1 plain, 2 seed d+1
    logic [5:0]  r_bidx, n_bidx;      // byte counter incl. seed bytes
    logic [31:0] r_seed, n_seed;
    logic [7:0]  r_fp, n_fp;
    logic [13:0] r_slot, n_slot;
    logic [BW-1:0] r_bucket, n_bucket;
    t_rsp   r_rsp, n_rsp;
    logic   r_done, n_done;

    // shared unit controls
    logic        w_ld, w_step;
    logic [31:0] w_init, w_hash;
    logic [7:0]  w_byte;
    logic        w_mstart, w_mdone;
    logic [16:0] w_den, w_rem;
    logic [5:0]  w_nbytes;
    logic [31:0] w_stroke;
    logic [2:0]  w_sidx;
    logic        w_seeded;
    logic [16:0] w_nb_eff, w_ne_eff;

    mphf_fnv u_fnv (
        .i_clk(i_clk), .i_load(w_ld), .i_init(w_init), .i_step(w_step),
        .i_byte(w_byte), .o_hash(w_hash)
    );
    mphf_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_num(w_hash),
        .i_den(w_den), .o_done(w_mdone), .o_rem(w_rem)
    );

    // clamped moduli
    always_comb begin
        w_nb_eff = (r_nb == 13'd0) ? 17'd1 : {4'd0, r_nb};
        if (w_nb_eff > 17'(NUM_BUCKETS)) w_nb_eff = 17'(NUM_BUCKETS);
        w_ne_eff = (r_ne == 15'd0) ? 17'd1 : {2'd0, r_ne};
        if (w_ne_eff > 17'(NUM_SLOTS)) w_ne_eff = 17'(NUM_SLOTS);
    end

    // byte select: seeded passes hash 4 seed bytes first
    assign w_seeded = (r_pass != 2'd1);
    assign w_nbytes = {r_req.stroke_count[3:0], 2'b00} + (w_seeded ? 6'd4 : 6'd0);
    always_comb begin
        logic [5:0] kb;
        kb = r_bidx - (w_seeded ? 6'd4 : 6'd0);
        w_sidx = kb[4:2];
        case (w_sidx)
            3'd0: w_stroke = r_req.stroke_0;
            3'd1: w_stroke = r_req.stroke_1;
            3'd2: w_stroke = r_req.stroke_2;
            3'd3: w_stroke = r_req.stroke_3;
            3'd4: w_stroke = r_req.stroke_4;
            3'd5: w_stroke = r_req.stroke_5;
            3'd6: w_stroke = r_req.stroke_6;
            default: w_stroke = r_req.stroke_7;
        endcase
        if (w_seeded && r_bidx < 6'd4) begin
            w_byte = r_seed[8*r_bidx[1:0] +: 8];
        end else begin
            w_byte = w_stroke[8*kb[1:0] +: 8];
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass = r_pass;
        n_bidx = r_bidx;
        n_seed = r_seed;
        n_fp = r_fp;
        n_slot = r_slot;
        n_bucket = r_bucket;
        n_rsp = r_rsp;
        n_done = 1'b0;
        w_ld = 1'b0;
        w_init = FNV_BASIS;
        w_step = 1'b0;
        w_mstart = 1'b0;
        w_den = (r_pass == 2'd0) ? w_nb_eff : w_ne_eff;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rsp = '0;
                    if (i_req.operation == OP_LOOKUP) begin
                        if (i_req.stroke_count == 4'd0 ||
                            32'(i_req.stroke_count) > 32'(MAX_STROKES)) begin
                            n_rsp.status = ST_BAD_COUNT;
                            n_state = S_DONE;
                        end else begin
                            n_pass = 2'd0;
                            n_bidx = '0;
                            n_seed = '0;
                            w_ld = 1'b1;
                            n_state = S_HASH;
                        end
                    end else begin
                        n_state = S_DONE;
                        if (i_req.operation == OP_WR_DISP) begin
                            n_rsp.status = (32'(i_req.table_index) >= 32'(NUM_BUCKETS))
                                ? ST_INDEX_RANGE : ST_WRITTEN;
                        end else begin
                            n_rsp.status = (32'(i_req.table_index) >= 32'(NUM_SLOTS))
                                ? ST_INDEX_RANGE : ST_WRITTEN;
                        end
                    end
                end
            end
            S_HASH: begin
                if (r_bidx == w_nbytes) begin
                    if (r_pass == 2'd1) begin
                        n_fp = w_hash[7:0];
                        n_pass = 2'd2;
                        n_bidx = '0;
                        w_ld = 1'b1;
                    end else begin
                        w_mstart = 1'b1;
                        n_state = S_MOD;
                    end
                end else begin
                    w_step = 1'b1;
                    n_bidx = r_bidx + 6'd1;
                end
            end
            S_MOD: begin
                if (w_mdone) begin
                    if (r_pass == 2'd0) begin
                        n_bucket = w_rem[BW-1:0];
                        n_state = S_RD_DISP;
                    end else begin
                        n_slot = 14'(w_rem);
                        n_state = S_RD_SLOT;
                    end
                end
            end
            S_RD_DISP: begin
                // r_disp_q valid this cycle; plain pass next
                n_seed = 32'(r_disp_q) + 32'd1;
                n_pass = 2'd1;
                n_bidx = '0;
                w_ld = 1'b1;
                n_state = S_HASH;
            end
            S_RD_SLOT: n_state = S_CHECK;
            S_CHECK: begin
                n_rsp.slot = r_slot;
                if (r_fp_q != r_fp) begin
                    n_rsp.status = ST_FP_MISMATCH;
                end else if ({1'b0, 16'(r_val_q)} >= r_nu) begin
                    n_rsp.status = ST_VALUE_RANGE;
                end else begin
                    n_rsp.status = ST_FOUND;
                    n_rsp.value_id = 16'(r_val_q);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // displacement read is held in S_RD_DISP while r_dwait, set when the bucket modulo finishes, is high
    logic r_dwait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
            r_nb <= 13'd1;
            r_ne <= 15'd1;
            r_nu <= 17'd0;
            r_dwait <= 1'b0;
        end else begin
            r_dwait <= (r_state == S_MOD) && w_mdone && (r_pass == 2'd0);
            if (r_state == S_RD_DISP && r_dwait) begin
                r_state <= r_state;
            end else begin
                r_state <= n_state;
            end
            r_done <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUCKETS: r_nb <= i_cfg_data[12:0];
                    CFG_ENTRIES: r_ne <= i_cfg_data[14:0];
                    CFG_UNIQUE: r_nu <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(r_state == S_RD_DISP && r_dwait)) begin
            r_pass <= n_pass;
            r_bidx <= n_bidx;
            r_seed <= n_seed;
            r_fp <= n_fp;
            r_slot <= n_slot;
            r_bucket <= n_bucket;
            r_rsp <= n_rsp;
        end
        if (r_state == S_IDLE && i_start) r_req <= i_req;
    end

    // table ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            if (i_req.operation == OP_WR_DISP &&
                32'(i_req.table_index) < 32'(NUM_BUCKETS)) begin
                disp_mem[i_req.table_index[BW-1:0]] <= DISP_WIDTH'(i_req.table_data);
            end
            if (i_req.operation == OP_WR_FP &&
                32'(i_req.table_index) < 32'(NUM_SLOTS)) begin
                fp_mem[i_req.table_index[SW-1:0]] <= i_req.table_data[7:0];
            end
            if (i_req.operation == OP_WR_VAL &&
                32'(i_req.table_index) < 32'(NUM_SLOTS)) begin
                val_mem[i_req.table_index[SW-1:0]] <= VALUE_WIDTH'(i_req.table_data);
            end
        end
        r_disp_q <= disp_mem[r_bucket];
        r_fp_q <= fp_mem[r_slot[SW-1:0]];
        r_val_q <= val_mem[r_slot[SW-1:0]];
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp = r_rsp;
    assign o_cfg_ready = (r_state == S_IDLE);

    // a result strobe always comes with an idle core
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    // a strobe only comes out of the final state
    `ASSERT_IMP(a_done_src, i_clk, i_rst_n, o_done, $past(r_state) == S_DONE)
    // start in idle always makes the core busy
    `ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
endmodule

// ===== tb/sv/mphf_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// mphf lookup checker
// watches the request, result and register channels of the lookup core,
// keeps its own copy of the tables and registers, and compares every result
// ----------------------------------------------------------------------------
module mphf_lookup_checker
    import mphf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_done,
    input  t_rsp        i_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int BUCKET_DEPTH = 4096;
    localparam int SLOT_DEPTH = 16384;
    localparam int STROKE_MAX = 8;

    logic [15:0] disp_mem [BUCKET_DEPTH];
    logic [7:0]  fp_mem [SLOT_DEPTH];
    logic [15:0] vid_mem [SLOT_DEPTH];
    logic [12:0] bucket_reg;
    logic [14:0] entry_reg;
    logic [16:0] unique_reg;
    t_rsp        rsp_fifo [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending = rsp_fifo.size();

    // fnv-1a over the four little-endian bytes of a word
    function automatic logic [31:0] fnv_word(logic [31:0] h, logic [31:0] w);
        for (int b = 0; b < 4; b++) begin
            h = (h ^ {24'd0, w[8*b +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic [31:0] key_fnv(logic [31:0] h, t_req r);
        logic [31:0] w [8];
        w = '{r.stroke_0, r.stroke_1, r.stroke_2, r.stroke_3,
              r.stroke_4, r.stroke_5, r.stroke_6, r.stroke_7};
        for (int i = 0; i < STROKE_MAX && i < int'(r.stroke_count); i++) begin
            h = fnv_word(h, w[i]);
        end
        return h;
    endfunction

    function automatic logic [31:0] seeded_hash(logic [31:0] seed, t_req r);
        return key_fnv(fnv_word(FNV_BASIS, seed), r);
    endfunction

    function automatic logic [7:0] plain_fp(t_req r);
        logic [31:0] h;
        h = key_fnv(FNV_BASIS, r);
        return h[7:0];
    endfunction

    function automatic int clamp_mod(int v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // expected result of one request; table writes land in the local copy
    function automatic t_rsp resolve_request(t_req r);
        t_rsp        res;
        int          bucket;
        int          slot;
        logic [31:0] d;
        res = '0;
        case (r.operation)
            OP_WR_DISP: begin
                if (r.table_index >= BUCKET_DEPTH) begin
                    res.status = ST_INDEX_RANGE;
                end else begin
                    disp_mem[r.table_index] = r.table_data;
                    res.status = ST_WRITTEN;
                end
            end
            OP_WR_FP, OP_WR_VAL: begin
                if (r.table_index >= SLOT_DEPTH) begin
                    res.status = ST_INDEX_RANGE;
                end else begin
                    if (r.operation == OP_WR_FP) fp_mem[r.table_index] = r.table_data[7:0];
                    else vid_mem[r.table_index] = r.table_data;
                    res.status = ST_WRITTEN;
                end
            end
            default: begin
                if (r.stroke_count == 0 || r.stroke_count > STROKE_MAX) begin
                    res.status = ST_BAD_COUNT;
                end else begin
                    bucket = int'(seeded_hash(32'd0, r)
                        % clamp_mod(int'(bucket_reg), BUCKET_DEPTH));
                    d = {16'd0, disp_mem[bucket]} + 32'd1;
                    slot = int'(seeded_hash(d, r)
                        % clamp_mod(int'(entry_reg), SLOT_DEPTH));
                    res.slot = slot[13:0];
                    if (fp_mem[slot] != plain_fp(r)) begin
                        res.status = ST_FP_MISMATCH;
                    end else if ({1'b0, vid_mem[slot]} >= unique_reg) begin
                        res.status = ST_VALUE_RANGE;
                    end else begin
                        res.status = ST_FOUND;
                        res.value_id = vid_mem[slot];
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            bucket_reg = 13'd1;
            entry_reg = 15'd1;
            unique_reg = 17'd0;
            rsp_fifo.delete();
            fail_count = 0;
        end else begin
            if (i_done) begin
                if (rsp_fifo.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, i_rsp);
                    fail_count++;
                end else begin
                    want = rsp_fifo.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        fail_count++;
                    end
                    if (i_rsp.value_id !== want.value_id) begin
                        $display("%0t: value_id expected %0d actual %0d",
                                 $time, want.value_id, i_rsp.value_id);
                        fail_count++;
                    end
                    if (i_rsp.slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d",
                                 $time, want.slot, i_rsp.slot);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUCKETS: bucket_reg = i_cfg_data[12:0];
                    CFG_ENTRIES: entry_reg = i_cfg_data[14:0];
                    CFG_UNIQUE:  unique_reg = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) rsp_fifo.push_back(resolve_request(i_req));
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// lookup core testbench top
// drives table loads and key lookups through the request port and register
// settings through the config channel; a side checker predicts every result
// ----------------------------------------------------------------------------
module tb_top;
    import mphf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_req        i_req;
    logic        o_busy;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;

    // shadow of what stimulus has stored, used only to steer lookups onto
    // written entries; the checker keeps its own copy for prediction
    bit          disp_ok [4096];
    bit          fp_ok [16384];
    bit          vid_ok [16384];
    logic [15:0] disp_shadow [4096];
    int          cfg_buckets;
    int          cfg_entries;
    int          cfg_unique;
    int          idle_pct;
    int          n_writes;
    int          n_lookups;
    int          n_settings;
    t_req        recent_keys [$];

    mphf_dictionary_lookup_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mphf_lookup_checker CHK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // hard stop well past the slowest legal run
    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    function automatic t_req random_req(logic [1:0] op);
        t_req         r;
        logic [319:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
        r = bits[$bits(t_req)-1:0];
        r.operation = op;
        return r;
    endfunction

    // one transaction on the request port, with an optional idle gap first;
    // start stays high into the next transaction when there is no gap
    task automatic send_req(t_req r);
        bit gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            if (!gap) i_start <= 1'b0;
            gap = 1;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        if (r.operation == OP_LOOKUP) n_lookups++;
        else n_writes++;
        if (r.operation == OP_WR_DISP && r.table_index < 4096) begin
            disp_ok[r.table_index] = 1;
            disp_shadow[r.table_index] = r.table_data;
        end
        if (r.operation == OP_WR_FP && r.table_index < 16384) fp_ok[r.table_index] = 1;
        if (r.operation == OP_WR_VAL && r.table_index < 16384) vid_ok[r.table_index] = 1;
    endtask

    task automatic write_entry(logic [1:0] op, int idx, logic [15:0] data);
        t_req r;
        r = random_req(op);
        r.table_index = idx[13:0];
        r.table_data = data;
        send_req(r);
    endtask

    // lookup with every entry it reads written first; optionally refreshes
    // the entries and steers the fingerprint and value id toward a hit
    task automatic prepared_lookup(t_req r, bit refresh, bit fp_hit, bit vid_hit);
        int          nb;
        int          ne;
        int          bucket;
        int          slot;
        logic [31:0] d;
        logic [15:0] data;
        nb = cfg_buckets == 0 ? 1 : (cfg_buckets > 4096 ? 4096 : cfg_buckets);
        ne = cfg_entries == 0 ? 1 : (cfg_entries > 16384 ? 16384 : cfg_entries);
        bucket = int'(CHK.seeded_hash(32'd0, r) % nb);
        if (refresh || !disp_ok[bucket]) write_entry(OP_WR_DISP, bucket, 16'($urandom));
        d = {16'd0, disp_shadow[bucket]} + 32'd1;
        slot = int'(CHK.seeded_hash(d, r) % ne);
        if (refresh || !fp_ok[slot]) begin
            data = 16'($urandom);
            if (fp_hit) data[7:0] = CHK.plain_fp(r);
            write_entry(OP_WR_FP, slot, data);
        end
        if (refresh || !vid_ok[slot]) begin
            data = 16'($urandom);
            if (vid_hit && cfg_unique > 0)
                data = (cfg_unique > 65536) ? data : 16'($urandom_range(cfg_unique - 1));
            write_entry(OP_WR_VAL, slot, data);
        end
        send_req(r);
        recent_keys.push_back(r);
        if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    endtask

    function automatic t_req random_key(int count);
        t_req r;
        r = random_req(OP_LOOKUP);
        r.stroke_count = count[3:0];
        return r;
    endfunction

    // register writes only once every expected result is back
    task automatic set_registers(int buckets, int entries, int uniq);
        int vals [3];
        vals = '{buckets, entries, uniq};
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= i[1:0];
            // bits above the register width are junk the block must drop
            i_cfg_data <= (32'($urandom) << (i == 0 ? 13 : (i == 1 ? 15 : 17)))
                          | 32'(vals[i]);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_buckets = buckets;
        cfg_entries = entries;
        cfg_unique = uniq;
        n_settings++;
    endtask

    initial begin
        int   settings [7][3];
        int   pct [4];
        t_req r;
        int   pick;
        settings = '{'{0, 0, 0}, '{8191, 32767, 131071}, '{7, 13, 5},
                     '{4096, 16384, 65536}, '{1, 1, 1}, '{100, 300, 65535},
                     '{33, 50, 20}};
        pct = '{0, 76, 0, 35};
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BUCKETS;
        i_cfg_data <= '0;
        cfg_buckets = 1;
        cfg_entries = 1;
        cfg_unique = 0;
        idle_pct = 0;
        n_writes = 0;
        n_lookups = 0;
        n_settings = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table edges, out-of-range writes, bad counts, zero and
        // saturating moduli, extreme keys
        set_registers(0, 0, 0);
        write_entry(OP_WR_DISP, 0, 16'hFFFF);
        write_entry(OP_WR_DISP, 4095, 16'h0000);
        write_entry(OP_WR_DISP, 4096, 16'h1234);
        write_entry(OP_WR_DISP, 16383, 16'hFFFF);
        write_entry(OP_WR_FP, 16383, 16'hFFFF);
        write_entry(OP_WR_VAL, 16383, 16'hFFFF);
        write_entry(OP_WR_VAL, 0, 16'h0000);
        for (int c = 0; c < 16; c += 1) begin
            if (c == 0 || c >= 9) send_req(random_key(c));
        end
        r = random_key(1);
        r.stroke_0 = '0;
        prepared_lookup(r, 1, 1, 1);
        set_registers(8191, 32767, 131071);
        r = random_key(8);
        r.stroke_0 = '1; r.stroke_1 = '1; r.stroke_2 = '1; r.stroke_3 = '1;
        r.stroke_4 = '1; r.stroke_5 = '1; r.stroke_6 = '1; r.stroke_7 = '1;
        prepared_lookup(r, 1, 1, 1);
        prepared_lookup(random_key(3), 1, 0, 1);
        prepared_lookup(random_key(5), 1, 1, 0);

        // random: mostly well-formed load-then-lookup sequences, some noise
        for (int p = 0; p < 14; p++) begin
            set_registers(settings[p % 7][0], settings[p % 7][1], settings[p % 7][2]);
            idle_pct = pct[p % 4];
            for (int k = 0; k < 24; k++) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    r = random_req(2'($urandom_range(1, 3)));
                    if ($urandom_range(1)) r.table_index = 14'($urandom_range(4095));
                    send_req(r);
                end else if (pick < 16) begin
                    send_req(random_key($urandom_range(1) ? 0 : $urandom_range(9, 15)));
                end else if (pick < 36 && recent_keys.size() > 0) begin
                    prepared_lookup(recent_keys[$urandom_range(recent_keys.size() - 1)],
                                    0, 1, 1);
                end else begin
                    prepared_lookup(random_key($urandom_range(99) < 70 ?
                                    $urandom_range(1, 3) : $urandom_range(4, 8)),
                                    $urandom_range(99) < 60,
                                    $urandom_range(99) < 75, $urandom_range(99) < 80);
                end
            end
        end
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d table writes and %0d lookups under %0d register settings",
                 n_writes, n_lookups, n_settings);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== mphf_dictionary_lookup_core.f =====
+incdir+design
design/mphf_pkg.sv
design/mphf_fnv.sv
design/mphf_mod.sv
design/mphf_dictionary_lookup_core.sv
tb/sv/mphf_lookup_checker.sv
tb/sv/tb_top.sv
